/* sv/ring_buffer_deque_macros.svh */
// Assertion macros for the ring buffer deque checker.
// No dependencies; included by the checker file.
`ifndef RING_BUFFER_DEQUE_MACROS_SVH
`define RING_BUFFER_DEQUE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RBD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define RBD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/rbd_pkg.sv */
// Shared types, widths and codes for the ring buffer deque.
// No dependencies.
`timescale 1ns / 1ps

package rbd_pkg;

    localparam int KIND_W   = 3;
    localparam int VALUE_W  = 32;
    localparam int INDEX_W  = 4;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    localparam int DEF_DEPTH      = 16;
    localparam int DEF_ELEM_WIDTH = 32;

    localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd1;
    localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_READ       = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                rd_ok;
        logic [COUNT_W-1:0]  count;
    } t_ctl;

endpackage

/* sv/rbd_in_if.sv */
// Command channel of the ring buffer deque: valid/ready with one item payload.
// Depends on rbd_pkg.
`timescale 1ns / 1ps

interface rbd_in_if import rbd_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  kind;
    logic [VALUE_W-1:0] value;
    logic [INDEX_W-1:0] index;

    modport source (output valid, kind, value, index, input ready);
    modport sink   (input valid, kind, value, index, output ready);
endinterface

/* sv/rbd_out_if.sv */
// Result channel of the ring buffer deque: valid/ready with one item payload.
// Depends on rbd_pkg.
`timescale 1ns / 1ps

interface rbd_out_if import rbd_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  data;
    logic [COUNT_W-1:0]  count;

    modport source (output valid, status, data, count, input ready);
    modport sink   (input valid, status, data, count, output ready);
endinterface

/* sv/ring_buffer_deque.sv */
// Top level of the ring buffer deque: control, element store, output register.
// Depends on rbd_pkg, rbd_in_if, rbd_out_if, rbd_ctrl and rbd_mem.
//
// Usage:
//   i_cmd carries one operation per item: kind (push back, push front,
//   pop back, pop front, read at index), value for pushes, index for reads.
//   o_rsp returns exactly one item per command: status, count after the
//   operation and, for a successful read, the element data (zero otherwise).
//   Throughput is one item per cycle while o_rsp does not stall. A result
//   passes through the registered read of the element store and then the
//   output register. Each item makes at most one store access, and a write
//   lands before the next item's read, so no forwarding path is needed.
//   Reset clears head, tail and count; store contents stay undefined until
//   pushed, and no clearing pass runs. When o_rsp stalls, the output register
//   holds, the pipeline stage behind it fills, and i_cmd.ready then drops
//   until the result is taken.
`timescale 1ns / 1ps

module ring_buffer_deque import rbd_pkg::*; #(
    parameter int DEPTH      = DEF_DEPTH,
    parameter int ELEM_WIDTH = DEF_ELEM_WIDTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rbd_in_if.sink     i_cmd,
    rbd_out_if.source  o_rsp
);

    localparam int PW = $clog2(DEPTH);
    localparam int SW = (ELEM_WIDTH < VALUE_W) ? ELEM_WIDTH : VALUE_W;

    t_ctl                ctl;
    logic                fire;
    logic                in_ready;
    logic                p1_move;
    logic                wr_en, rd_en;
    logic [PW-1:0]       addr;
    logic [SW-1:0]       rdata;

    logic                r_p1_valid, n_p1_valid;
    t_ctl                r_p1_ctl;
    logic                r_out_valid, n_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    logic [VALUE_W-1:0]  r_out_data;
    logic [COUNT_W-1:0]  r_out_count;

    assign p1_move  = r_p1_valid && (!r_out_valid || o_rsp.ready);
    assign in_ready = !r_p1_valid || p1_move;
    assign fire     = i_cmd.valid && in_ready;

    rbd_ctrl #(.DEPTH(DEPTH)) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_kind  (i_cmd.kind),
        .i_index (i_cmd.index),
        .o_ctl   (ctl),
        .o_wr_en (wr_en),
        .o_rd_en (rd_en),
        .o_addr  (addr)
    );

    rbd_mem #(.DEPTH(DEPTH), .WIDTH(SW)) u_mem (
        .i_clk   (i_clk),
        .i_wr_en (wr_en),
        .i_rd_en (rd_en),
        .i_addr  (addr),
        .i_wdata (i_cmd.value[SW-1:0]),
        .o_rdata (rdata)
    );

    always_comb begin
        n_p1_valid = r_p1_valid;
        if (fire) begin
            n_p1_valid = 1'b1;
        end else if (p1_move) begin
            n_p1_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (p1_move) begin
            n_out_valid = 1'b1;
        end else if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_p1_valid  <= n_p1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_p1_ctl <= ctl;
        end
        if (p1_move) begin
            r_out_status <= r_p1_ctl.status;
            r_out_count  <= r_p1_ctl.count;
            r_out_data   <= r_p1_ctl.rd_ok ? VALUE_W'(rdata) : '0;
        end
    end

    assign i_cmd.ready  = in_ready;
    assign o_rsp.valid  = r_out_valid;
    assign o_rsp.status = r_out_status;
    assign o_rsp.data   = r_out_data;
    assign o_rsp.count  = r_out_count;

endmodule

/* sv/rbd_mem.sv */
// Element store: single-port synchronous memory, registered read data.
// No package dependencies.
`timescale 1ns / 1ps

module rbd_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_rd_en) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/rbd_ctrl.sv */
// Head, tail and count registers; decodes each item into a store access
// and its status. Depends on rbd_pkg.
`timescale 1ns / 1ps

module rbd_ctrl import rbd_pkg::*; #(
    parameter int DEPTH = DEF_DEPTH
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_fire,
    input  logic [KIND_W-1:0]        i_kind,
    input  logic [INDEX_W-1:0]       i_index,
    output t_ctl                     o_ctl,
    output logic                     o_wr_en,
    output logic                     o_rd_en,
    output logic [$clog2(DEPTH)-1:0] o_addr
);

    localparam int PW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int SUMW = ((PW > INDEX_W) ? PW : INDEX_W) + 1;
    localparam int CMPW = (CW > INDEX_W) ? CW : INDEX_W;

    localparam logic [PW-1:0]   LAST_SLOT = PW'(DEPTH - 1);
    localparam logic [CW-1:0]   FULL_CNT  = CW'(DEPTH);
    localparam logic [SUMW-1:0] WRAP      = SUMW'(DEPTH);

    logic [PW-1:0]   r_head, n_head;
    logic [PW-1:0]   r_tail, n_tail;
    logic [CW-1:0]   r_count, n_count;
    logic [PW-1:0]   head_next, head_prev, tail_next, tail_prev;
    logic [SUMW-1:0] sum;
    logic [SUMW-1:0] pos;
    logic            full, empty, idx_ok;
    logic [STATUS_W-1:0] status;
    logic            rd_ok;

    assign head_next = (r_head == LAST_SLOT) ? '0 : r_head + 1'b1;
    assign head_prev = (r_head == '0) ? LAST_SLOT : r_head - 1'b1;
    assign tail_next = (r_tail == LAST_SLOT) ? '0 : r_tail + 1'b1;
    assign tail_prev = (r_tail == '0) ? LAST_SLOT : r_tail - 1'b1;

    assign full   = (r_count == FULL_CNT);
    assign empty  = (r_count == '0);
    assign idx_ok = CMPW'(i_index) < CMPW'(r_count);
    assign sum    = SUMW'(r_head) + SUMW'(i_index);
    assign pos    = (sum >= WRAP) ? sum - WRAP : sum;

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        status  = ST_OK;
        rd_ok   = 1'b0;
        o_wr_en = 1'b0;
        o_rd_en = 1'b0;
        o_addr  = r_tail;
        unique case (i_kind)
            KIND_PUSH_BACK: begin
                if (full) begin
                    status = ST_FULL;
                end else begin
                    o_wr_en = i_fire;
                    o_addr  = r_tail;
                    n_tail  = tail_next;
                    n_count = r_count + 1'b1;
                end
            end
            KIND_PUSH_FRONT: begin
                if (full) begin
                    status = ST_FULL;
                end else begin
                    o_wr_en = i_fire;
                    o_addr  = head_prev;
                    n_head  = head_prev;
                    n_count = r_count + 1'b1;
                end
            end
            KIND_POP_BACK: begin
                if (empty) begin
                    status = ST_EMPTY;
                end else begin
                    n_tail  = tail_prev;
                    n_count = r_count - 1'b1;
                end
            end
            KIND_POP_FRONT: begin
                if (empty) begin
                    status = ST_EMPTY;
                end else begin
                    n_head  = head_next;
                    n_count = r_count - 1'b1;
                end
            end
            KIND_READ: begin
                if (!idx_ok) begin
                    status = ST_RANGE;
                end else begin
                    rd_ok   = 1'b1;
                    o_rd_en = i_fire;
                    o_addr  = pos[PW-1:0];
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else if (i_fire) begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    assign o_ctl.status = status;
    assign o_ctl.rd_ok  = rd_ok;
    assign o_ctl.count  = COUNT_W'(n_count);

endmodule

/* sv/rbd_checker.sv */
// Port-level checker for the ring buffer deque, bound to the top level.
// Depends on rbd_pkg and ring_buffer_deque_macros.svh.
`timescale 1ns / 1ps
`include "ring_buffer_deque_macros.svh"

module rbd_checker import rbd_pkg::*; #(
    parameter int DEPTH = DEF_DEPTH
) (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input logic [STATUS_W-1:0] i_out_status,
    input logic [VALUE_W-1:0]  i_out_data,
    input logic [COUNT_W-1:0]  i_out_count
);

    localparam logic [COUNT_W-1:0] FULL_CNT = COUNT_W'(DEPTH);

    `RBD_ASSERT_NEXT(a_hold_stall, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_status) && $stable(i_out_data) && $stable(i_out_count), "result changed while stalled")
    `RBD_ASSERT_NOW(a_full_count, i_clk, i_rst_n, i_out_valid && (i_out_status == ST_FULL), i_out_count == FULL_CNT, "dropped push without full count")
    `RBD_ASSERT_NOW(a_empty_count, i_clk, i_rst_n, i_out_valid && (i_out_status == ST_EMPTY), i_out_count == '0, "ignored pop with nonzero count")
    `RBD_ASSERT_NOW(a_err_data, i_clk, i_rst_n, i_out_valid && (i_out_status != ST_OK), i_out_data == '0, "error result carries data")

endmodule

bind ring_buffer_deque rbd_checker #(.DEPTH(DEPTH)) u_rbd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_rsp.valid),
    .i_out_ready  (o_rsp.ready),
    .i_out_status (o_rsp.status),
    .i_out_data   (o_rsp.data),
    .i_out_count  (o_rsp.count)
);
